// ----- hw/rtl/v3n_pkg.sv -----
package v3n_pkg;

	localparam int CB    = 16;
	localparam int SB    = 2 * CB;
	localparam int RB    = CB;
	localparam int UB    = 15;
	localparam int AW    = 2 * SB + 2;
	localparam int OW    = 16;
	localparam int NSTG  = 16;
	localparam int NLANE = 3;

	typedef struct packed {
		logic [RB-1:0] r;
		logic [SB-1:0] s;
		logic          zero;
	} sqrt_stage_t;

	typedef struct packed {
		logic [UB-1:0]        q;
		logic signed [AW-1:0] a;
		logic signed [AW-1:0] b;
		logic [SB-1:0]        s;
		logic [SB-1:0]        sq;
		logic                 neg;
	} unit_stage_t;

endpackage

// ----- hw/rtl/v3n_prep.sv -----
module v3n_prep
	import v3n_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CB-1:0] comp,
	output logic [SB-1:0]        sq_s1,
	output logic                 neg_s1
);

	logic [CB-1:0] mag;

	assign mag = comp[CB-1] ? CB'(-comp) : CB'(comp);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1  <= SB'({{CB{1'b0}}, mag} * {{CB{1'b0}}, mag});
			neg_s1 <= comp[CB-1];
		end
	end

endmodule

// ----- hw/rtl/v3n_lane.sv -----
module v3n_lane
	import v3n_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic [SB-1:0]        s,
	input  logic [SB-1:0]        sq,
	input  logic                 neg,
	output logic signed [OW-1:0] unit
);

	// one quotient bit per stage, d = 2q-1, a = d*d*s, b = d*s
	function automatic unit_stage_t unit_step(input unit_stage_t p, input int bi);
		unit_stage_t          n;
		logic signed [AW-1:0] sx;
		logic signed [AW-1:0] m;
		logic signed [AW-1:0] cand;
		n    = p;
		sx   = $signed({{(AW-SB){1'b0}}, p.s});
		m    = $signed({{(AW-SB-30){1'b0}}, p.sq, 30'b0});
		cand = p.a + (p.b <<< (bi + 2)) + (sx <<< (2 * bi + 2));
		if (cand <= m && !p.q[UB-1]) begin
			n.q = p.q | (UB'(1) << bi);
			n.a = cand;
			n.b = p.b + (sx <<< (bi + 1));
		end
		return n;
	endfunction

	unit_stage_t          init;
	unit_stage_t          pipe_s [UB];
	logic signed [OW-1:0] unit_s;

	always_comb begin
		init.q   = '0;
		init.s   = s;
		init.sq  = sq;
		init.neg = neg;
		init.a   = $signed({{(AW-SB){1'b0}}, s});
		init.b   = -$signed({{(AW-SB){1'b0}}, s});
	end

	for (genvar k = 0; k < UB; k++) begin : g_stage
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					pipe_s[k] <= unit_step(init, UB - 1);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					pipe_s[k] <= unit_step(pipe_s[k-1], UB - 1 - k);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unit_s <= pipe_s[UB-1].neg ? -$signed({1'b0, pipe_s[UB-1].q})
			                           :  $signed({1'b0, pipe_s[UB-1].q});
		end
	end

	assign unit = unit_s;

endmodule

// ----- hw/rtl/v3n_sqrt.sv -----
module v3n_sqrt
	import v3n_pkg::*;
(
	input  logic          clk,
	input  logic          en,
	input  logic [SB-1:0] s,
	input  logic          zero,
	output logic [RB-1:0] root,
	output logic          zero_out
);

	function automatic sqrt_stage_t sqrt_step(input sqrt_stage_t p, input int bi);
		sqrt_stage_t   n;
		logic [RB-1:0] t;
		n = p;
		t = p.r | (RB'(1) << bi);
		if (({{RB{1'b0}}, t} * {{RB{1'b0}}, t}) <= p.s) n.r = t;
		return n;
	endfunction

	sqrt_stage_t init;
	sqrt_stage_t pipe_s [NSTG];

	assign init = '{r: '0, s: s, zero: zero};

	for (genvar k = 0; k < NSTG; k++) begin : g_stage
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					pipe_s[k] <= sqrt_step(init, RB - 1);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					pipe_s[k] <= sqrt_step(pipe_s[k-1], RB - 1 - k);
				end
			end
		end
	end

	assign root     = pipe_s[NSTG-1].r;
	assign zero_out = pipe_s[NSTG-1].zero;

endmodule

// ----- hw/rtl/vector3_normalize_core.sv -----
// Normalizes one 3D vector per beat: signed Q7.8 components in, the floor of the
// Euclidean length as unsigned Q8.8 and the unit vector as rounded signed Q1.14 out,
// with zero_vector set and all outputs zero for a null vector. Fully pipelined:
// a new beat is taken every cycle unless the output stalls, and each result comes
// from the 16-stage bit-per-stage square root and the matching 15-stage quotient
// pipeline in each of the three component lanes. When the output register holds
// an untaken result, the whole pipeline waits with it.
module vector3_normalize_core
	import v3n_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [CB-1:0] x_component,
	input  logic signed [CB-1:0] y_component,
	input  logic signed [CB-1:0] z_component,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OW-1:0]        length,
	output logic signed [OW-1:0] unit_x,
	output logic signed [OW-1:0] unit_y,
	output logic signed [OW-1:0] unit_z,
	output logic                 zero_vector
);

	logic                 en;
	logic signed [CB-1:0] comp [NLANE];
	logic [SB-1:0]        sq_s1 [NLANE];
	logic                 neg_s1 [NLANE];
	logic [SB-1:0]        sq_s2 [NLANE];
	logic                 neg_s2 [NLANE];
	logic [SB-1:0]        s_s2;
	logic                 zero_s2;
	logic signed [OW-1:0] unit [NLANE];
	logic [RB-1:0]        root;
	logic                 zero_p;
	logic                 v_s1, v_s2;
	logic [NSTG-1:0]      vp_q;
	logic                 out_valid_q;
	logic [OW-1:0]        length_q;
	logic signed [OW-1:0] unit_q [NLANE];
	logic                 zero_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	assign comp[0] = x_component;
	assign comp[1] = y_component;
	assign comp[2] = z_component;

	for (genvar i = 0; i < NLANE; i++) begin : g_lane
		v3n_prep u_prep (
			.clk    (clk),
			.en     (en),
			.comp   (comp[i]),
			.sq_s1  (sq_s1[i]),
			.neg_s1 (neg_s1[i])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s2[i]  <= sq_s1[i];
				neg_s2[i] <= neg_s1[i];
			end
		end

		v3n_lane u_lane (
			.clk  (clk),
			.en   (en),
			.s    (s_s2),
			.sq   (sq_s2[i]),
			.neg  (neg_s2[i]),
			.unit (unit[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s2    <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			zero_s2 <= (sq_s1[0] | sq_s1[1] | sq_s1[2]) == '0;
		end
	end

	v3n_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.s        (s_s2),
		.zero     (zero_s2),
		.root     (root),
		.zero_out (zero_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			vp_q        <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			vp_q        <= {vp_q[NSTG-2:0], v_s2};
			out_valid_q <= vp_q[NSTG-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			length_q <= OW'(root);
			zero_q   <= zero_p;
			for (int i = 0; i < NLANE; i++) begin
				unit_q[i] <= zero_p ? '0 : unit[i];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign length      = length_q;
	assign unit_x      = unit_q[0];
	assign unit_y      = unit_q[1];
	assign unit_z      = unit_q[2];
	assign zero_vector = zero_q;

`ifndef SYNTH
	a_zero_clears : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_vector |-> length == '0 && unit_x == '0 && unit_y == '0
			&& unit_z == '0)
		else $error("zero vector result not cleared");

	a_len_nonzero : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !zero_vector |-> length != '0)
		else $error("nonzero vector with zero length");

	a_unit_range : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> unit_x >= -16'sd16384 && unit_x <= 16'sd16384
			&& unit_y >= -16'sd16384 && unit_y <= 16'sd16384
			&& unit_z >= -16'sd16384 && unit_z <= 16'sd16384)
		else $error("unit component out of range");
`endif

endmodule

// ----- tb/vector3_normalize_core_tb.sv -----
`timescale 1ns / 1ps

module vector3_normalize_core_tb
	import v3n_pkg::*;
;

	typedef struct {
		logic [15:0] len;
		logic [15:0] ux;
		logic [15:0] uy;
		logic [15:0] uz;
		logic        zv;
	} norm_result_t;

	function automatic longint unsigned root_floor(longint unsigned s);
		longint unsigned r, t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= s) r = t;
		end
		return r;
	endfunction

	function automatic longint unsigned unit_round(longint unsigned m, longint unsigned s);
		longint unsigned q, t, d, rhs;
		q = 0;
		rhs = (m * m) << 30;
		for (int b = 14; b >= 0; b--) begin
			t = q | (64'd1 << b);
			d = 2 * t - 1;
			if (t <= 16384 && d * d * s <= rhs) q = t;
		end
		return q;
	endfunction

	function automatic norm_result_t normalize(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		norm_result_t r;
		logic [15:0] c[3];
		longint unsigned m[3];
		logic ng[3];
		longint unsigned s, l, q;
		logic [15:0] u[3];
		c[0] = x; c[1] = y; c[2] = z;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			ng[i] = c[i][15];
			m[i] = ng[i] ? longint'(16'(-c[i])) : longint'(c[i]);
			if (ng[i] && c[i] == 16'h8000) m[i] = 32768;
			s += m[i] * m[i];
		end
		if (s == 0) begin
			r = '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1};
			return r;
		end
		l = root_floor(s);
		if (l > 65535) l = 65535;
		for (int i = 0; i < 3; i++) begin
			q = unit_round(m[i], s);
			u[i] = ng[i] ? 16'(-q) : 16'(q);
		end
		r = '{16'(l), u[0], u[1], u[2], 1'b0};
		return r;
	endfunction

	class norm_scoreboard;
		norm_result_t pending[$];
		int errors;
		int checked;

		function void note_vector(logic [15:0] x, logic [15:0] y, logic [15:0] z);
			pending.push_back(normalize(x, y, z));
		endfunction

		function void check_result(norm_result_t got);
			norm_result_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result len=%0d", got.len);
				return;
			end
			e = pending.pop_front();
			checked++;
			if (e.len !== got.len || e.ux !== got.ux || e.uy !== got.uy ||
					e.uz !== got.uz || e.zv !== got.zv) begin
				errors++;
				if (errors <= 10)
					$display("mismatch exp len=%0d u=%0d,%0d,%0d z=%0d got len=%0d u=%0d,%0d,%0d z=%0d",
						e.len, $signed(e.ux), $signed(e.uy), $signed(e.uz), e.zv,
						got.len, $signed(got.ux), $signed(got.uy), $signed(got.uz), got.zv);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [CB-1:0] x_component = 0, y_component = 0, z_component = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [OW-1:0] length;
	logic signed [OW-1:0] unit_x, unit_y, unit_z;
	logic zero_vector;

	norm_scoreboard sb = new();
	int cycles = 0;
	bit no_idle = 0;
	int zero_count = 0;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	vector3_normalize_core dut (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("FAILED: results differ");
			$finish;
		end
		if (in_valid && in_ready) begin
			sb.note_vector(x_component, y_component, z_component);
			if (x_component == 0 && y_component == 0 && z_component == 0) zero_count++;
		end
		if (out_valid && out_ready)
			sb.check_result('{length, unit_x, unit_y, unit_z, zero_vector});
	end

	initial begin
		int gap;
		forever begin
			@(posedge clk);
			if (no_idle) out_ready <= 1;
			else if ($urandom_range(3) == 0) begin
				gap = $urandom_range(1, 14);
				out_ready <= 0;
				repeat (gap) @(posedge clk);
				out_ready <= 1;
			end else out_ready <= 1;
		end
	end

	task automatic send_vector(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		int gap;
		if (!no_idle && $urandom_range(5) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		x_component <= x;
		y_component <= y;
		z_component <= z;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_comp();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 8)) - 16'd4;
			3: return 16'($urandom_range(0, 1023)) - 16'd512;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] d[12][3];
		d = '{'{0, 0, 0}, '{16'h8000, 16'h8000, 16'h8000}, '{16'h7fff, 16'h7fff, 16'h7fff},
			'{16'h8000, 0, 0}, '{0, 16'h8000, 0}, '{0, 0, 16'h8000},
			'{1, 0, 0}, '{16'hffff, 0, 0}, '{0, 1, 16'hffff},
			'{16'h7fff, 16'h8000, 1}, '{3, 4, 0}, '{16'hffff, 16'hffff, 16'hffff}};
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (d[i]) send_vector(d[i][0], d[i][1], d[i][2]);
		for (int n = 0; n < 1650; n++) begin
			if (n == 800) begin
				in_valid <= 0;
				@(posedge clk);
				while (sb.pending.size() != 0) @(posedge clk);
			end
			if (n == 1300) no_idle = 1;
			if ($urandom_range(30) == 0) send_vector(0, 0, 0);
			else send_vector(pick_comp(), pick_comp(), pick_comp());
		end
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("checked %0d normalized vectors, %0d of them null, including extreme components",
			sb.checked, zero_count);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
